[rtl/core/prlb_pkg.sv]
package prlb_pkg;

  localparam int MAX_PAGES      = 16;
  localparam int MAX_PAGE_BYTES = 512;

  localparam int PAGE_W = $clog2(MAX_PAGES);
  localparam int OFS_W  = $clog2(MAX_PAGE_BYTES);
  localparam int FILL_W = OFS_W + 1;
  localparam int ADDR_W = PAGE_W + OFS_W;
  localparam int DEPTH  = MAX_PAGES * MAX_PAGE_BYTES;

  localparam int CMD_W   = 3;
  localparam int DATA_W  = 8;
  localparam int AVAIL_W = 13;
  localparam int RPG_W   = 5;
  localparam int BPP_W   = 10;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam int BPP_MIN   = 16;
  localparam int AVAIL_MAX = 8191;

  localparam logic [RPG_W-1:0]  RPG_RESET   = RPG_W'(16);
  localparam logic [BPP_W-1:0]  BPP_RESET   = BPP_W'(264);
  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE     = 3'd0,
    CMD_READ      = 3'd1,
    CMD_PEEK      = 3'd2,
    CMD_AVAIL     = 3'd3,
    CMD_ERASE_ALL = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGES_IN_USE   = 1'b0,
    REG_BYTES_PER_PAGE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [OFS_W-1:0]  offset;
  } ptr_t;

  function automatic logic [RPG_W-1:0] ring_pages(input logic [RPG_W-1:0] v);
    logic [RPG_W-1:0] r;
    if (v == '0) begin
      r = RPG_W'(1);
    end else if (int'(v) > MAX_PAGES) begin
      r = RPG_W'(MAX_PAGES);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [BPP_W-1:0] page_bytes(input logic [BPP_W-1:0] v);
    logic [BPP_W-1:0] r;
    if (int'(v) < BPP_MIN) begin
      r = BPP_W'(BPP_MIN);
    end else if (int'(v) > MAX_PAGE_BYTES) begin
      r = BPP_W'(MAX_PAGE_BYTES);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [PAGE_W-1:0] next_page(input logic [PAGE_W-1:0] p,
                                                  input logic [RPG_W-1:0]  rpg);
    logic [PAGE_W-1:0] r;
    if (int'(p) + 1 >= int'(rpg)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic logic offset_wraps(input logic [OFS_W-1:0] o,
                                        input logic [BPP_W-1:0] pb);
    return (int'(o) + 1 >= int'(pb));
  endfunction

endpackage

[rtl/core/prlb_if.sv]
interface prlb_in_if import prlb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, cmd, write_data, input ready);
  modport sink (input valid, cmd, write_data, output ready);
endinterface

interface prlb_out_if import prlb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic [AVAIL_W-1:0] bytes_available;

  modport source (output valid, read_data, bytes_available, input ready);
  modport sink (input valid, read_data, bytes_available, output ready);
endinterface

[rtl/core/paged_ring_log_buffer_core.sv]
// Paged ring log buffer. Requests arrive on in_req (valid/ready) with a command and a byte;
// each request produces exactly one response on out_rsp carrying the byte read (read or
// peek, otherwise zero) and the number of bytes between the read and write positions.
// The ring geometry is set through the cfg_ write port; the user must write it only while
// no request is in flight, which the block itself does not enforce. A request is accepted
// only when the controller is idle. In the accept cycle the byte store is written or read
// and both pointers are updated. In the ST_RESP state that follows, the registered read
// byte is taken, the byte count is formed and the response is loaded into the output
// register once it is free; the controller then returns to idle and accepts again.
// If the receiver stalls, the response is held in the output register and the next
// request is still accepted; it then waits in its count cycle until the output register
// is taken, and no further request is accepted meanwhile.
// Reset (and the erase-all command) clears the pointers and a per-page fill mark; bytes
// at or beyond a page's fill mark read as erased (0xFF), so no clearing pass is needed
// and requests are accepted right after reset.
module paged_ring_log_buffer_core import prlb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  prlb_in_if.sink               in_req,
  prlb_out_if.source            out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic {ST_IDLE, ST_RESP} state_t;

  state_t             state_r;
  cmd_t               cmd_r;
  logic               rd_hit_r;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_read_data_r;
  logic [AVAIL_W-1:0] out_avail_r;

  logic [RPG_W-1:0]  pages_r;
  logic [BPP_W-1:0]  bpp_r;
  logic [RPG_W-1:0]  rpg;
  logic [BPP_W-1:0]  pb;

  ptr_t wr_ptr_r, wr_ptr_nxt;
  ptr_t rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r [MAX_PAGES];

  logic               accept;
  cmd_t               cmd_w;
  logic               do_write;
  logic               do_fetch;
  logic               wr_wrap;
  logic               clr_all;
  logic               rd_hit_nxt;
  logic [DATA_W-1:0]  ram_rdata;
  logic [DATA_W-1:0]  rd_val;
  logic [AVAIL_W-1:0] avail_w;

  assign rpg      = ring_pages(pages_r);
  assign pb       = page_bytes(bpp_r);
  assign accept   = in_req.valid && in_req.ready;
  assign cmd_w    = cmd_t'(in_req.cmd);
  assign do_write = accept && (cmd_w == CMD_WRITE);
  assign do_fetch = accept && ((cmd_w == CMD_READ) || (cmd_w == CMD_PEEK));
  assign wr_wrap  = offset_wraps(wr_ptr_r.offset, pb);
  assign rd_hit_nxt = FILL_W'(rd_ptr_r.offset) < fill_r[rd_ptr_r.page];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_r <= RPG_RESET;
      bpp_r   <= BPP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAGES_IN_USE:   pages_r <= cfg_wdata[RPG_W-1:0];
        REG_BYTES_PER_PAGE: bpp_r   <= cfg_wdata[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    clr_all    = 1'b0;
    if (accept) begin
      unique case (cmd_w)
        CMD_WRITE: begin
          if (wr_wrap) begin
            wr_ptr_nxt.offset = '0;
            wr_ptr_nxt.page   = next_page(wr_ptr_r.page, rpg);
            if (wr_ptr_nxt.page == rd_ptr_r.page) begin
              rd_ptr_nxt.page   = next_page(rd_ptr_r.page, rpg);
              rd_ptr_nxt.offset = '0;
            end
          end else begin
            wr_ptr_nxt.offset = wr_ptr_r.offset + 1'b1;
          end
        end
        CMD_READ: begin
          if (offset_wraps(rd_ptr_r.offset, pb)) begin
            rd_ptr_nxt.offset = '0;
            rd_ptr_nxt.page   = next_page(rd_ptr_r.page, rpg);
          end else begin
            rd_ptr_nxt.offset = rd_ptr_r.offset + 1'b1;
          end
        end
        CMD_ERASE_ALL: begin
          wr_ptr_nxt = '0;
          rd_ptr_nxt = '0;
          clr_all    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      for (int i = 0; i < MAX_PAGES; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      if (clr_all) begin
        for (int i = 0; i < MAX_PAGES; i++) begin
          fill_r[i] <= '0;
        end
      end else if (do_write) begin
        if (!wr_wrap || (wr_ptr_nxt.page != wr_ptr_r.page)) begin
          fill_r[wr_ptr_r.page] <= FILL_W'(wr_ptr_r.offset) + FILL_W'(1);
        end
        if (wr_wrap) begin
          fill_r[wr_ptr_nxt.page] <= '0;
        end
      end
    end
  end

  prlb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_write),
    .waddr (wr_ptr_r),
    .wdata (in_req.write_data),
    .re    (do_fetch),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  prlb_avail u_avail (
    .wr_ptr       (wr_ptr_r),
    .rd_ptr       (rd_ptr_r),
    .ring_pages_i (rpg),
    .page_bytes_i (pb),
    .avail        (avail_w)
  );

  always_comb begin
    if ((cmd_r == CMD_READ) || (cmd_r == CMD_PEEK)) begin
      rd_val = rd_hit_r ? ram_rdata : ERASED_BYTE;
    end else begin
      rd_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (out_valid_r && out_rsp.ready) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            state_r  <= ST_RESP;
            cmd_r    <= cmd_w;
            rd_hit_r <= rd_hit_nxt;
          end
        end
        ST_RESP: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r     <= 1'b1;
            out_read_data_r <= rd_val;
            out_avail_r     <= avail_w;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_req.ready            = (state_r == ST_IDLE);
  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.read_data       = out_read_data_r;
  assign out_rsp.bytes_available = out_avail_r;

  a_accept_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RESP))
    else $error("accepted request did not enter the response cycle");

  a_fill_tracks_writer: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[wr_ptr_r.page] == FILL_W'(wr_ptr_r.offset))
    else $error("fill mark of the write page differs from the write offset");

  a_resp_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RESP) && !out_valid_r) |=> ((state_r == ST_IDLE) && out_valid_r))
    else $error("response not loaded into a free output register");

endmodule

[rtl/core/prlb_ram.sv]
module prlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/prlb_avail.sv]
module prlb_avail import prlb_pkg::*; (
  input  ptr_t               wr_ptr,
  input  ptr_t               rd_ptr,
  input  logic [RPG_W-1:0]   ring_pages_i,
  input  logic [BPP_W-1:0]   page_bytes_i,
  output logic [AVAIL_W-1:0] avail
);

  localparam int SUM_W = RPG_W + BPP_W + 1;

  logic [SUM_W-1:0] w_pos;
  logic [SUM_W-1:0] r_pos;
  logic [SUM_W-1:0] ring;
  logic [SUM_W-1:0] diff;

  always_comb begin
    w_pos = SUM_W'(wr_ptr.page) * SUM_W'(page_bytes_i) + SUM_W'(wr_ptr.offset);
    r_pos = SUM_W'(rd_ptr.page) * SUM_W'(page_bytes_i) + SUM_W'(rd_ptr.offset);
    ring  = SUM_W'(ring_pages_i) * SUM_W'(page_bytes_i);
    if (w_pos >= r_pos) begin
      diff = w_pos - r_pos;
    end else begin
      diff = w_pos + ring - r_pos;
    end
    if (diff > SUM_W'(AVAIL_MAX)) begin
      avail = AVAIL_W'(AVAIL_MAX);
    end else begin
      avail = diff[AVAIL_W-1:0];
    end
  end

endmodule
